@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: ante implies cons");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: ante implies cons one cycle later");

`endif

@@ rtl/dgsp_pkg.sv @@
`default_nettype none

package dgsp_pkg;

  localparam int MAX_NODES_DEF   = 16;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int NODE_PORT_W   = 4;
  localparam int WEIGHT_PORT_W = 16;
  localparam int CFG_W         = 5;
  localparam int DIST_W        = 20;

  localparam logic [DIST_W-1:0] DIST_MAX       = 20'hFFFFF;
  localparam logic [CFG_W-1:0]  NODE_COUNT_RST = 5'd16;

  localparam logic ACT_EDGE = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WR_A,
    S_WR_B,
    S_START,
    S_PASS,
    S_SETTLE
  } state_t;

  typedef struct packed {
    logic valid;
    logic relax_en;
    logic settled;
    logic reached;
    logic clear;
  } relax_ctl_t;

endpackage

`default_nettype wire

@@ rtl/dgsp_ram.sv @@
`default_nettype none

module dgsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/dgsp_relax_unit.sv @@
`default_nettype none

module dgsp_relax_unit
  import dgsp_pkg::*;
#(
  parameter int NODE_W      = 4,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire relax_ctl_t             ctl,
  input  wire logic [NODE_W-1:0]      idx,
  input  wire logic [WEIGHT_BITS-1:0] w,
  input  wire logic [DIST_W-1:0]      d,
  input  wire logic [DIST_W-1:0]      base,
  output logic                        upd,
  output logic      [DIST_W-1:0]      nd,
  output logic                        found,
  output logic      [DIST_W-1:0]      best,
  output logic      [NODE_W-1:0]      best_idx,
  output logic                        unset_found,
  output logic      [NODE_W-1:0]      unset_idx
);

  localparam int SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

  logic [SUM_W-1:0]  sum;
  logic [DIST_W-1:0] d_new;
  logic              r_new;
  logic              cand;
  logic              first_open;

  // A relaxed node competes for the next pick with its updated distance.
  assign sum   = SUM_W'(base) + SUM_W'(w);
  assign nd    = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
  assign upd   = ctl.valid && ctl.relax_en && !ctl.settled && (w != '0) &&
                 (!ctl.reached || (nd < d));
  assign d_new = upd ? nd : d;
  assign r_new = ctl.reached || upd;
  assign cand  = ctl.valid && !ctl.settled && r_new && (!found || (d_new < best));
  assign first_open = ctl.valid && !ctl.settled && !unset_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      found       <= 1'b0;
      unset_found <= 1'b0;
    end else if (ctl.clear) begin
      found       <= 1'b0;
      unset_found <= 1'b0;
    end else begin
      if (cand) begin
        found <= 1'b1;
      end
      if (first_open) begin
        unset_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cand) begin
      best     <= d_new;
      best_idx <= idx;
    end
    if (first_open) begin
      unset_idx <= idx;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dense_graph_shortest_paths_core.sv @@
// Edge write: busy in S_WR_A and S_WR_B after acceptance; a bad endpoint leaves busy low.
// Run over n nodes: the origin result is registered out of S_START, then one result
// per further node, each after one scan over the edge and distance memories; an
// origin outside the n nodes gives no result. One shared relax unit serves every scan.
// Reset clears all MAX_NODES * MAX_NODES edge memory entries with busy high.
// Results are strobed for one cycle each; the receiver cannot stall them.
`default_nettype none
`include "assert_macros.svh"

module dense_graph_shortest_paths_core
  import dgsp_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     action,
  input  wire logic [NODE_PORT_W-1:0]   from_node,
  input  wire logic [NODE_PORT_W-1:0]   to_node,
  input  wire logic [WEIGHT_PORT_W-1:0] weight,
  input  wire logic [NODE_PORT_W-1:0]   origin_node,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_W-1:0]         cfg_data,
  output logic                          result_valid,
  output logic      [NODE_PORT_W-1:0]   node_index,
  output logic      [DIST_W-1:0]        path_length,
  output logic                          reachable,
  output logic                          last_result
);

  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;
  localparam int ADDR_W    = $clog2(MAT_DEPTH);

  function automatic logic [ADDR_W-1:0] mat_addr(input logic [NODE_W-1:0] row,
                                                 input logic [NODE_W-1:0] col);
    mat_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_NODES) + ADDR_W'(col));
  endfunction

  state_t state, state_next;

  logic [CFG_W-1:0]       node_count;
  logic [ADDR_W-1:0]      clr_addr;
  logic [NODE_W-1:0]      wa, wb;
  logic [WEIGHT_BITS-1:0] wval;
  logic [NODE_W-1:0]      org;
  logic                   org_ok;
  logic [CNT_W-1:0]       n_eff;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       idx;
  logic                   v1;
  logic [NODE_W-1:0]      idx1;
  logic [NODE_W-1:0]      cur;
  logic [DIST_W-1:0]      base;
  logic                   relax_en;
  logic [MAX_NODES-1:0]   settled;
  logic [MAX_NODES-1:0]   reached;

  logic                   accept;
  logic                   edge_ok;
  logic [CNT_W-1:0]       n_calc;
  logic                   issue;
  logic                   pass_begin;
  logic                   emit_start;
  logic                   emit_settle;
  logic [CNT_W-1:0]       cnt_inc;
  logic [NODE_W-1:0]      pick;

  logic                   mat_we;
  logic [ADDR_W-1:0]      mat_waddr;
  logic [WEIGHT_BITS-1:0] mat_wdata;
  logic [WEIGHT_BITS-1:0] mat_rdata;
  logic [DIST_W-1:0]      dist_rdata;

  relax_ctl_t             ctl;
  logic                   upd;
  logic [DIST_W-1:0]      nd;
  logic                   found;
  logic [DIST_W-1:0]      best;
  logic [NODE_W-1:0]      best_idx;
  logic                   unset_found;
  logic [NODE_W-1:0]      unset_idx;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign edge_ok = (32'(from_node) < MAX_NODES) && (32'(to_node) < MAX_NODES);

  always_comb begin
    if (node_count == '0) begin
      n_calc = CNT_W'(1);
    end else if (32'(node_count) > MAX_NODES) begin
      n_calc = CNT_W'(MAX_NODES);
    end else begin
      n_calc = CNT_W'(node_count);
    end
  end

  assign issue       = (state == S_PASS) && (idx < n_eff);
  assign pass_begin  = (state == S_START) || (state == S_SETTLE);
  assign emit_start  = (state == S_START) && org_ok;
  assign emit_settle = (state == S_SETTLE);
  assign cnt_inc     = cnt + CNT_W'(1);
  assign pick        = found ? best_idx : unset_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(MAT_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_RUN) begin
            state_next = S_START;
          end else if (edge_ok) begin
            state_next = S_WR_A;
          end
        end
      end
      S_WR_A: begin
        state_next = S_WR_B;
      end
      S_WR_B: begin
        state_next = S_IDLE;
      end
      S_START: begin
        if (!org_ok || (n_eff == CNT_W'(1))) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_PASS;
        end
      end
      S_PASS: begin
        if (!issue && !v1) begin
          state_next = S_SETTLE;
        end
      end
      S_SETTLE: begin
        if (cnt_inc == n_eff) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_PASS;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    mat_we    = 1'b0;
    mat_waddr = clr_addr;
    mat_wdata = '0;
    case (state)
      S_CLEAR: begin
        mat_we = 1'b1;
      end
      S_WR_A: begin
        mat_we    = 1'b1;
        mat_waddr = mat_addr(wa, wb);
        mat_wdata = wval;
      end
      S_WR_B: begin
        mat_we    = 1'b1;
        mat_waddr = mat_addr(wb, wa);
        mat_wdata = wval;
      end
      default: begin
        mat_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count   <= NODE_COUNT_RST;
      clr_addr     <= '0;
      cnt          <= '0;
      idx          <= '0;
      v1           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_data;
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      v1           <= issue;
      result_valid <= emit_start || emit_settle;
      if (pass_begin) begin
        idx <= '0;
      end else if (issue) begin
        idx <= idx + CNT_W'(1);
      end
      if (state == S_START) begin
        cnt <= CNT_W'(1);
      end else if (state == S_SETTLE) begin
        cnt <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= idx[NODE_W-1:0];
    if (accept) begin
      wa     <= NODE_W'(from_node);
      wb     <= NODE_W'(to_node);
      wval   <= WEIGHT_BITS'(weight);
      org    <= NODE_W'(origin_node);
      org_ok <= (32'(origin_node) < 32'(n_calc));
      n_eff  <= n_calc;
    end
    if (upd) begin
      reached[idx1] <= 1'b1;
    end
    if (state == S_START) begin
      settled      <= MAX_NODES'(1) << org;
      reached      <= '0;
      cur          <= org;
      base         <= '0;
      relax_en     <= 1'b1;
      node_index   <= NODE_PORT_W'(org);
      path_length  <= '0;
      reachable    <= 1'b1;
      last_result  <= (n_eff == CNT_W'(1));
    end
    if (state == S_SETTLE) begin
      settled[pick] <= 1'b1;
      cur           <= pick;
      base          <= best;
      relax_en      <= found;
      node_index    <= NODE_PORT_W'(pick);
      path_length   <= found ? best : '0;
      reachable     <= found;
      last_result   <= (cnt_inc == n_eff);
    end
  end

  dgsp_ram #(
    .WIDTH(WEIGHT_BITS),
    .DEPTH(MAT_DEPTH)
  ) u_edge_ram (
    .clk  (clk),
    .we   (mat_we),
    .waddr(mat_waddr),
    .wdata(mat_wdata),
    .raddr(mat_addr(cur, idx[NODE_W-1:0])),
    .rdata(mat_rdata)
  );

  dgsp_ram #(
    .WIDTH(DIST_W),
    .DEPTH(MAX_NODES)
  ) u_dist_ram (
    .clk  (clk),
    .we   (upd),
    .waddr(idx1),
    .wdata(nd),
    .raddr(idx[NODE_W-1:0]),
    .rdata(dist_rdata)
  );

  always_comb begin
    ctl.valid    = v1;
    ctl.relax_en = relax_en;
    ctl.settled  = settled[idx1];
    ctl.reached  = reached[idx1];
    ctl.clear    = pass_begin;
  end

  dgsp_relax_unit #(
    .NODE_W     (NODE_W),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_relax (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .idx        (idx1),
    .w          (mat_rdata),
    .d          (dist_rdata),
    .base       (base),
    .upd        (upd),
    .nd         (nd),
    .found      (found),
    .best       (best),
    .best_idx   (best_idx),
    .unset_found(unset_found),
    .unset_idx  (unset_idx)
  );

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy && (action == ACT_RUN), busy)
  `ASSERT_IMPLIES(a_last_idle, clk, rst, result_valid && last_result, !busy)
  `ASSERT_IMPLIES(a_no_result_clear, clk, rst, state == S_CLEAR, !result_valid)
  `ASSERT_IMPLIES(a_pick_open, clk, rst, state == S_SETTLE,
                  (found || unset_found) && !settled[pick])

endmodule

`default_nettype wire

@@ tb/dense_graph_shortest_paths_core_test.sv @@
`timescale 1ns / 100ps

module dense_graph_shortest_paths_core_test;
  import dgsp_pkg::*;

  localparam int NODES = MAX_NODES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 21;

  typedef logic [NODE_PORT_W-1:0] node_t;
  typedef logic [WEIGHT_PORT_W-1:0] weight_t;

  typedef struct packed {
    node_t node;
    logic [DIST_W-1:0] plen;
    logic reach;
    logic last;
  } settle_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic action = ACT_EDGE;
  node_t from_node = '0;
  node_t to_node = '0;
  weight_t weight = '0;
  node_t origin_node = '0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic result_valid;
  node_t node_index;
  logic [DIST_W-1:0] path_length;
  logic reachable;
  logic last_result;

  weight_t adj_weight [NODES][NODES] = '{default: '0};
  logic [CFG_W-1:0] node_cfg = NODE_COUNT_RST;
  settle_t pending_settles[$];
  settle_t want;
  bit gaps_on = 1'b1;
  int cycle_count = 0;
  int error_count = 0;
  int items_sent = 0;
  int runs_sent = 0;
  int results_seen = 0;

  dense_graph_shortest_paths_core u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .from_node(from_node),
    .to_node(to_node),
    .weight(weight),
    .origin_node(origin_node),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .node_index(node_index),
    .path_length(path_length),
    .reachable(reachable),
    .last_result(last_result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int active_nodes();
    if (node_cfg == 0) return 1;
    if (node_cfg > NODES) return NODES;
    return node_cfg;
  endfunction

  function automatic void store_edge(input node_t a, input node_t b, input weight_t w);
    adj_weight[a][b] = w;
    adj_weight[b][a] = w;
  endfunction

  // Settles nodes in order of distance, lowest index first on a tie, and queues one
  // expected result per node. Unreachable leftovers follow in ascending index.
  function automatic void predict_run(input node_t org);
    int n, cnt, nx, i;
    bit found;
    bit done [NODES];
    bit seen [NODES];
    logic [DIST_W-1:0] best_len [NODES];
    logic [DIST_W:0] sum;
    n = active_nodes();
    if (org >= n) return;
    for (i = 0; i < n; i++) begin
      seen[i] = adj_weight[org][i] != 0;
      best_len[i] = adj_weight[org][i];
      done[i] = 1'b0;
    end
    best_len[org] = '0;
    seen[org] = 1'b1;
    done[org] = 1'b1;
    cnt = 1;
    pending_settles.push_back('{node: org, plen: '0, reach: 1'b1, last: cnt == n});
    while (cnt < n) begin
      found = 1'b0;
      nx = 0;
      for (i = 0; i < n; i++) begin
        if (!done[i] && seen[i] && (!found || best_len[i] < best_len[nx])) begin
          nx = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        for (i = n - 1; i >= 0; i--) begin
          if (!done[i]) nx = i;
        end
      end
      done[nx] = 1'b1;
      if (found) begin
        for (i = 0; i < n; i++) begin
          if (!done[i] && adj_weight[nx][i] != 0) begin
            sum = best_len[nx] + adj_weight[nx][i];
            if (sum > DIST_MAX) sum = DIST_MAX;
            if (!seen[i] || sum[DIST_W-1:0] < best_len[i]) begin
              best_len[i] = sum[DIST_W-1:0];
              seen[i] = 1'b1;
            end
          end
        end
      end
      cnt++;
      pending_settles.push_back('{node: node_t'(nx),
                                  plen: found ? best_len[nx] : {DIST_W{1'b0}},
                                  reach: found, last: cnt == n});
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      results_seen++;
      if (pending_settles.size() == 0) begin
        $error("unexpected result for node %0d", node_index);
        error_count++;
      end else begin
        want = pending_settles.pop_front();
        if (node_index !== want.node) begin
          $error("node_index: expected %0d, got %0d", want.node, node_index);
          error_count++;
        end
        if (path_length !== want.plen) begin
          $error("path_length: expected %0d, got %0d", want.plen, path_length);
          error_count++;
        end
        if (reachable !== want.reach) begin
          $error("reachable: expected %0d, got %0d", want.reach, reachable);
          error_count++;
        end
        if (last_result !== want.last) begin
          $error("last_result: expected %0d, got %0d", want.last, last_result);
          error_count++;
        end
      end
    end
  end

  task automatic send_item(input logic act, input node_t a, input node_t b,
                           input weight_t w, input node_t org);
    if (gaps_on && $urandom_range(99) < 21) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    from_node <= a;
    to_node <= b;
    weight <= w;
    origin_node <= org;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    items_sent++;
    if (act == ACT_EDGE) begin
      store_edge(a, b, w);
    end else begin
      runs_sent++;
      predict_run(org);
    end
  endtask

  task automatic send_edge(input node_t a, input node_t b, input weight_t w);
    send_item(ACT_EDGE, a, b, w, node_t'($urandom));
  endtask

  task automatic send_run(input node_t org);
    send_item(ACT_RUN, node_t'($urandom), node_t'($urandom), weight_t'($urandom), org);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_settles.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic set_node_count(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_cfg = value;
  endtask

  task automatic test_empty_graph();
    send_run(node_t'(0));
    send_run(node_t'(NODES - 1));
  endtask

  task automatic test_long_chain();
    int i;
    for (i = 0; i < NODES - 1; i++) send_edge(node_t'(i), node_t'(i + 1), '1);
    send_run(node_t'(0));
    send_edge(node_t'(5), node_t'(5), weight_t'(7));
    send_edge(node_t'(7), node_t'(8), '0);
    send_run(node_t'(NODES - 1));
  endtask

  task automatic test_equal_distance();
    send_edge(node_t'(0), node_t'(2), '1);
    send_run(node_t'(0));
  endtask

  task automatic test_node_count_limits();
    set_node_count(5'd4);
    send_run(node_t'(4));
    send_run(node_t'(3));
    set_node_count(5'd0);
    send_run(node_t'(0));
    send_run(node_t'(1));
    set_node_count(5'd31);
    send_run(node_t'(NODES - 1));
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] counts [PHASES] = '{5'd16, 5'd1, 5'd6, 5'd0, 5'd31, 5'd11};
    int p, k, n, roll;
    node_t a, b;
    weight_t w;
    for (p = 0; p < PHASES; p++) begin
      set_node_count(counts[p]);
      n = active_nodes();
      gaps_on = (p != 2);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == PHASE_ITEMS / 2) wait_idle();
        roll = $urandom_range(99);
        if (roll < 8) begin
          send_item(logic'($urandom), node_t'($urandom), node_t'($urandom),
                    weight_t'($urandom), node_t'($urandom));
        end else if (roll < 35) begin
          send_run($urandom_range(99) < 85 ? node_t'($urandom_range(n - 1))
                                           : node_t'($urandom));
        end else begin
          a = $urandom_range(99) < 90 ? node_t'($urandom_range(n - 1)) : node_t'($urandom);
          b = $urandom_range(99) < 90 ? node_t'($urandom_range(n - 1)) : node_t'($urandom);
          roll = $urandom_range(99);
          if (roll < 10) w = '0;
          else if (roll < 50) w = weight_t'($urandom_range(1, 16));
          else if (roll < 75) w = weight_t'($urandom);
          else w = weight_t'($urandom_range(60000, 65535));
          send_edge(a, b, w);
        end
      end
      send_run(node_t'($urandom_range(n - 1)));
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_graph();
    test_long_chain();
    test_equal_distance();
    test_node_count_limits();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items, %0d of them runs, and checked %0d settled nodes,",
             items_sent, runs_sent, results_seen);
    $display("over node counts from 0 to 31 with and without sender gaps.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
